[hw/rtl/mouse_event_processor_assert.svh]
// assertion macros for the mouse event processor
`ifndef MOUSE_EVENT_PROCESSOR_ASSERT_SVH
`define MOUSE_EVENT_PROCESSOR_ASSERT_SVH

`ifndef ASSERT_OFF
// clocked assertion, held off during reset
`define MEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// clocked assertion that is also checked during reset
`define MEP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MEP_ASSERT(lbl, prop, msg)
`define MEP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hw/rtl/mep_pkg.sv]
// shared types and constants for the mouse event processor
`timescale 1ns / 1ps

package mep_pkg;

  // default timestamp width
  localparam int TIME_BITS_DEF = 48;

  // field widths
  localparam int BTN_W   = 3;
  localparam int DELTA_W = 8;
  localparam int WHEEL_W = 4;
  localparam int CLK_W   = 2;
  localparam int KIND_W  = 2;
  localparam int XY_W    = 25;

  // configuration registers
  localparam int CW_W   = 24;
  localparam int SPD_W  = 21;
  localparam int ACC_W  = 21;
  localparam int CFG_DW = 24;
  localparam int CFG_IW = 2;

  localparam logic [CW_W-1:0]  CLICK_WINDOW_RST = CW_W'(500000);
  localparam logic [SPD_W-1:0] SPEED_RST        = SPD_W'(65536);
  localparam logic [ACC_W-1:0] ACCEL_RST        = ACC_W'(65536);

  // derived multiplier and divisor
  localparam int MUL_SHIFT = 15;
  localparam int DIV_SHIFT = 11;
  localparam int MUL_W     = SPD_W - MUL_SHIFT;
  localparam int DIV_W     = ACC_W - DIV_SHIFT;

  // serial datapath widths
  localparam int MAG_W  = DELTA_W;
  localparam int PROD_W = MAG_W + MUL_W;
  localparam int SQ_W   = 2 * PROD_W;

  // saturation limits of the pointer outputs
  localparam logic [XY_W-1:0] XY_POS_MAX = {1'b0, {(XY_W-1){1'b1}}};
  localparam logic [XY_W-1:0] XY_NEG_MAX = {1'b1, {(XY_W-1){1'b0}}};

  typedef enum logic [KIND_W-1:0] {
    EV_DOWN  = 2'd0,
    EV_UP    = 2'd1,
    EV_MOVED = 2'd2,
    EV_WHEEL = 2'd3
  } ev_kind_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_CLICK_WINDOW = 2'd0,
    CFG_SPEED        = 2'd1,
    CFG_ACCEL        = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [MUL_W-1:0] mul;
    logic [DIV_W-1:0] div;
  } accel_cfg_t;

  typedef struct packed {
    logic            done;
    logic [XY_W-1:0] res;
  } accel_rsp_t;

endpackage

[hw/rtl/mep_if.sv]
// report and event channel interfaces
`timescale 1ns / 1ps

interface mep_req_if
  import mep_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [BTN_W-1:0]          button_mask;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic signed [WHEEL_W-1:0] wheel_dx;
  logic signed [WHEEL_W-1:0] wheel_dy;
  logic [TIME_BITS-1:0]      stamp;

  modport source (
    output valid, button_mask, dx, dy, wheel_dx, wheel_dy, stamp,
    input  ready
  );
  modport sink (
    input  valid, button_mask, dx, dy, wheel_dx, wheel_dy, stamp,
    output ready
  );
endinterface

interface mep_evt_if
  import mep_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         event_kind;
  logic [TIME_BITS-1:0]      event_time;
  logic [BTN_W-1:0]          event_buttons;
  logic [CLK_W-1:0]          click_number;
  logic signed [XY_W-1:0]    out_x;
  logic signed [XY_W-1:0]    out_y;
  logic signed [WHEEL_W-1:0] out_wheel_x;
  logic signed [WHEEL_W-1:0] out_wheel_y;
  logic                      last;

  modport source (
    output valid, event_kind, event_time, event_buttons, click_number,
           out_x, out_y, out_wheel_x, out_wheel_y, last,
    input  ready
  );
  modport sink (
    input  valid, event_kind, event_time, event_buttons, click_number,
           out_x, out_y, out_wheel_x, out_wheel_y, last,
    output ready
  );
endinterface

[hw/rtl/mouse_event_processor.sv]
// Mouse event processor: a report becomes button, moved and wheel events.
// Without acceleration the report is captured and the sequencer goes straight to emit, where
// each event beat is loaded into the output register; with acceleration it first waits for
// an 8-step multiply, 14-step square, 28-step restoring divide and a clamp step, one serial
// unit per axis running in parallel. A report that makes no event leaves the block idle;
// else the next report is taken the cycle after the last beat is loaded, later under event stalls.
// Reset: asynchronous, active low; clears button, click and press-time state and
// loads click_window 500000, speed_setting 65536 and accel_setting 65536.
`timescale 1ns / 1ps
`include "mouse_event_processor_assert.svh"

module mouse_event_processor
  import mep_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  mep_req_if.sink           req_i,
  mep_evt_if.source         evt_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  // configuration registers
  logic [CW_W-1:0]  window_q;
  logic [SPD_W-1:0] speed_q;
  logic [ACC_W-1:0] accel_q;

  // block state
  state_e               st_q, st_d;
  logic [BTN_W-1:0]     held_q, held_d;
  logic [CLK_W-1:0]     click_cnt_q, click_cnt_d;
  logic [TIME_BITS-1:0] last_press_q, last_press_d;
  logic [2:0]           pend_q, pend_d;

  // captured report
  logic [BTN_W-1:0]     mask_q;
  logic [DELTA_W-1:0]   dx_q, dy_q;
  logic [WHEEL_W-1:0]   wx_q, wy_q;
  logic [TIME_BITS-1:0] stamp_q;
  logic                 down_q;
  logic [CLK_W-1:0]     down_click_q;
  logic                 use_accel_q;

  // output register
  logic                 ovalid_q;
  logic [KIND_W-1:0]    okind_q;
  logic [BTN_W-1:0]     obtn_q;
  logic [CLK_W-1:0]     oclick_q;
  logic [XY_W-1:0]      ox_q, oy_q;
  logic [WHEEL_W-1:0]   owx_q, owy_q;
  logic [TIME_BITS-1:0] otime_q;
  logic                 olast_q;

  logic                 accept;
  logic                 in_window;
  logic [BTN_W-1:0]     changed;
  logic                 move_ev, wheel_ev, accel_on;
  logic                 load;
  logic [2:0]           pend_nx;
  logic [TIME_BITS-1:0] gap;
  accel_cfg_t           acfg;
  accel_rsp_t           rsp_x, rsp_y;

  assign accept      = req_i.valid & req_i.ready;
  assign req_i.ready = (st_q == ST_IDLE);

  assign acfg.mul = speed_q[SPD_W-1:MUL_SHIFT];
  assign acfg.div = accel_q[ACC_W-1:DIV_SHIFT];

  // click window check and event selection for the incoming report
  always_comb begin
    gap       = req_i.stamp - last_press_q;
    in_window = (req_i.stamp < last_press_q)
                || (gap <= {{(TIME_BITS-CW_W){1'b0}}, window_q});
    changed   = held_q ^ req_i.button_mask;
    move_ev   = (req_i.dx != '0) || (req_i.dy != '0);
    wheel_ev  = (req_i.wheel_dx != '0) || (req_i.wheel_dy != '0);
    accel_on  = move_ev && (acfg.mul != '0) && (acfg.div != '0);
  end

  // click counter and button state update
  always_comb begin
    held_d       = held_q;
    click_cnt_d  = click_cnt_q;
    last_press_d = last_press_q;
    if (accept && (req_i.button_mask != '0)) begin
      last_press_d = req_i.stamp;
      if (in_window) begin
        case (click_cnt_q)
          2'd1:    click_cnt_d = 2'd2;
          2'd2:    click_cnt_d = 2'd3;
          default: click_cnt_d = 2'd1;
        endcase
      end else begin
        click_cnt_d = 2'd1;
      end
    end
    if (accept && (changed != '0)) begin
      held_d = req_i.button_mask;
    end
  end

  // per-axis acceleration units
  mep_accel u_accel_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept && accel_on),
    .raw_i  (req_i.dx),
    .cfg_i  (acfg),
    .rsp_o  (rsp_x)
  );

  mep_accel u_accel_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept && accel_on),
    .raw_i  (req_i.dy),
    .cfg_i  (acfg),
    .rsp_o  (rsp_y)
  );

  // beat issue: lowest pending event goes to the output register
  assign pend_nx = pend_q & (pend_q - 3'd1);
  assign load    = (st_q == ST_EMIT) && (pend_q != '0) && (!ovalid_q || evt_o.ready);

  // sequencer
  always_comb begin
    st_d   = st_q;
    pend_d = pend_q;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          pend_d = {wheel_ev, move_ev, (changed != '0)};
          if (accel_on) begin
            st_d = ST_CALC;
          end else if ((changed != '0) || move_ev || wheel_ev) begin
            st_d = ST_EMIT;
          end
        end
      end
      ST_CALC: begin
        if (rsp_x.done) begin
          st_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          pend_d = pend_nx;
          if (pend_nx == '0) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      pend_q       <= '0;
      held_q       <= '0;
      click_cnt_q  <= '0;
      last_press_q <= '0;
      ovalid_q     <= 1'b0;
      window_q     <= CLICK_WINDOW_RST;
      speed_q      <= SPEED_RST;
      accel_q      <= ACCEL_RST;
    end else begin
      st_q         <= st_d;
      pend_q       <= pend_d;
      held_q       <= held_d;
      click_cnt_q  <= click_cnt_d;
      last_press_q <= last_press_d;
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (evt_o.ready) begin
        ovalid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CLICK_WINDOW: window_q <= cfg_data_i[CW_W-1:0];
          CFG_SPEED:        speed_q  <= cfg_data_i[SPD_W-1:0];
          CFG_ACCEL:        accel_q  <= cfg_data_i[ACC_W-1:0];
          default:          ;
        endcase
      end
    end
  end

  // report capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mask_q       <= req_i.button_mask;
      dx_q         <= req_i.dx;
      dy_q         <= req_i.dy;
      wx_q         <= req_i.wheel_dx;
      wy_q         <= req_i.wheel_dy;
      stamp_q      <= req_i.stamp;
      down_q       <= ((changed & req_i.button_mask) != '0);
      down_click_q <= click_cnt_d;
      use_accel_q  <= accel_on;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      otime_q <= stamp_q;
      olast_q <= (pend_nx == '0);
      if (pend_q[0]) begin
        okind_q  <= down_q ? EV_DOWN : EV_UP;
        obtn_q   <= mask_q;
        oclick_q <= down_q ? down_click_q : CLK_W'(0);
        ox_q     <= {{(XY_W-DELTA_W){dx_q[DELTA_W-1]}}, dx_q};
        oy_q     <= {{(XY_W-DELTA_W){dy_q[DELTA_W-1]}}, dy_q};
        owx_q    <= '0;
        owy_q    <= '0;
      end else if (pend_q[1]) begin
        okind_q  <= EV_MOVED;
        obtn_q   <= mask_q;
        oclick_q <= '0;
        ox_q     <= use_accel_q ? rsp_x.res : {{(XY_W-DELTA_W){dx_q[DELTA_W-1]}}, dx_q};
        oy_q     <= use_accel_q ? rsp_y.res : {{(XY_W-DELTA_W){dy_q[DELTA_W-1]}}, dy_q};
        owx_q    <= '0;
        owy_q    <= '0;
      end else begin
        okind_q  <= EV_WHEEL;
        obtn_q   <= '0;
        oclick_q <= '0;
        ox_q     <= '0;
        oy_q     <= '0;
        owx_q    <= wx_q;
        owy_q    <= wy_q;
      end
    end
  end

  assign evt_o.valid         = ovalid_q;
  assign evt_o.event_kind    = okind_q;
  assign evt_o.event_time    = otime_q;
  assign evt_o.event_buttons = obtn_q;
  assign evt_o.click_number  = oclick_q;
  assign evt_o.out_x         = ox_q;
  assign evt_o.out_y         = oy_q;
  assign evt_o.out_wheel_x   = owx_q;
  assign evt_o.out_wheel_y   = owy_q;
  assign evt_o.last          = olast_q;

  // checks
  `MEP_ASSERT(a_accept_no_pending, accept |-> (pend_q == '0), "report taken with beats pending")
  `MEP_ASSERT(a_done_in_calc, rsp_x.done |-> (st_q == ST_CALC), "accel result outside calc")
  `MEP_ASSERT(a_axes_in_step, rsp_x.done == rsp_y.done, "accel axes out of step")
  `MEP_ASSERT(a_final_beat_last, (load && $onehot(pend_q)) |=> (evt_o.valid && evt_o.last), "no last")
  `MEP_ASSERT(a_press_counts, (accept && (req_i.button_mask != '0)) |=> (click_cnt_q != '0), "no count")

endmodule

[hw/rtl/mep_accel.sv]
// bit-serial pointer acceleration for one axis: (|d|*mul)^2 / div with the sign of d, saturated
`timescale 1ns / 1ps

module mep_accel
  import mep_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DELTA_W-1:0] raw_i,
  input  accel_cfg_t         cfg_i,
  output accel_rsp_t         rsp_o
);

  localparam int CNT_W = $clog2(SQ_W);

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_MUL  = 5'b00010,
    PH_SQR  = 5'b00100,
    PH_DIV  = 5'b01000,
    PH_FIN  = 5'b10000
  } phase_e;

  phase_e            ph_q, ph_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic              zero_q, zero_d;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [PROD_W-1:0] pm_q, pm_d;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [XY_W-1:0]   res_q, res_d;

  logic [PROD_W-1:0] prod_nx;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    rem_sub;
  logic              rem_ge;
  logic [XY_W-1:0]   q_mag;

  // one step of each phase
  always_comb begin
    prod_nx = {prod_q[PROD_W-2:0], 1'b0}
              + (mag_q[MAG_W-1] ? PROD_W'(cfg_i.mul) : PROD_W'(0));
    rem_sh  = {rem_q, sq_q[SQ_W-1]};
    rem_ge  = (rem_sh >= {1'b0, cfg_i.div});
    rem_sub = rem_sh - {1'b0, cfg_i.div};
    q_mag   = (sq_q == SQ_W'(0)) ? XY_W'(1) : sq_q[XY_W-1:0];
  end

  // sequencer and serial datapath
  always_comb begin
    ph_d   = ph_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    zero_d = zero_q;
    mag_d  = mag_q;
    prod_d = prod_q;
    pm_d   = pm_q;
    sq_d   = sq_q;
    rem_d  = rem_q;
    res_d  = res_q;
    case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          neg_d  = raw_i[DELTA_W-1];
          zero_d = (raw_i == DELTA_W'(0));
          mag_d  = raw_i[DELTA_W-1] ? (~raw_i + DELTA_W'(1)) : raw_i;
          prod_d = '0;
          cnt_d  = CNT_W'(MAG_W - 1);
          ph_d   = PH_MUL;
        end
      end
      PH_MUL: begin
        prod_d = prod_nx;
        mag_d  = {mag_q[MAG_W-2:0], 1'b0};
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(0)) begin
          pm_d  = prod_nx;
          sq_d  = '0;
          cnt_d = CNT_W'(PROD_W - 1);
          ph_d  = PH_SQR;
        end
      end
      PH_SQR: begin
        sq_d  = {sq_q[SQ_W-2:0], 1'b0} + (pm_q[PROD_W-1] ? SQ_W'(prod_q) : SQ_W'(0));
        pm_d  = {pm_q[PROD_W-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(0)) begin
          rem_d = '0;
          cnt_d = CNT_W'(SQ_W - 1);
          ph_d  = PH_DIV;
        end
      end
      PH_DIV: begin
        // restoring divide, one quotient bit shifted in per cycle
        rem_d = rem_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        sq_d  = {sq_q[SQ_W-2:0], rem_ge};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(0)) begin
          ph_d = PH_FIN;
        end
      end
      PH_FIN: begin
        // minimum of one, sign restored, clamp to the output range
        if (zero_q) begin
          res_d = '0;
        end else if (neg_q) begin
          res_d = (sq_q > SQ_W'(XY_NEG_MAX)) ? XY_NEG_MAX : (XY_W'(0) - q_mag);
        end else begin
          res_d = (sq_q > SQ_W'(XY_POS_MAX)) ? XY_POS_MAX : q_mag;
        end
        done_d = 1'b1;
        ph_d   = PH_IDLE;
      end
      default: begin
        ph_d = PH_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    zero_q <= zero_d;
    mag_q  <= mag_d;
    prod_q <= prod_d;
    pm_q   <= pm_d;
    sq_q   <= sq_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

[sim/mouse_event_processor_test.sv]
// self-checking testbench for the mouse event processor: report channel in, event channel out
`timescale 1ns / 1ps

module mouse_event_processor_test;
  import mep_pkg::*;

  localparam int TW = TIME_BITS_DEF;

  // cycles without any beat before the run is abandoned
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  // settle time after the last event
  localparam int unsigned DRAIN_CYCLES = 100;
  // random reports with some effect, per register setting
  localparam int unsigned ITEMS_PER_PHASE = 22;

  // pointer output limits as magnitudes
  localparam longint unsigned NEG_LIMIT = 64'd1 << (XY_W - 1);
  localparam longint unsigned POS_LIMIT = NEG_LIMIT - 1;

  typedef struct packed {
    logic [BTN_W-1:0]          buttons;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [WHEEL_W-1:0] wx;
    logic signed [WHEEL_W-1:0] wy;
    logic [TW-1:0]             stamp;
  } mouse_report_t;

  typedef struct packed {
    ev_kind_e                  kind;
    logic [TW-1:0]             at;
    logic [BTN_W-1:0]          buttons;
    logic [CLK_W-1:0]          clicks;
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [WHEEL_W-1:0] wx;
    logic signed [WHEEL_W-1:0] wy;
    logic                      last;
  } mouse_event_t;

  typedef struct packed {
    mouse_report_t rep;
    logic          typed;
    mouse_event_t  ev;
  } stim_row_t;

  typedef struct packed {
    logic [CW_W-1:0]  window;
    logic [SPD_W-1:0] speed;
    logic [ACC_W-1:0] accel;
  } mouse_setting_t;

  localparam mouse_event_t NO_EVENT = '0;

  // directed reports under the reset settings (multiplier 2, divisor 32)
  localparam int DIR_N = 24;
  localparam stim_row_t DIRECTED [DIR_N] = '{
    // idle report straight after reset
    '{'{3'd0, 8'sd0, 8'sd0, 4'sd0, 4'sd0, 48'd10}, 1'b0, NO_EVENT},
    // first press of left
    '{'{3'd1, 8'sd0, 8'sd0, 4'sd0, 4'sd0, 48'd100}, 1'b1,
      '{EV_DOWN, 48'd100, 3'd1, 2'd1, 25'sd0, 25'sd0, 4'sd0, 4'sd0, 1'b1}},
    // held: counter moves on silently
    '{'{3'd1, 8'sd0, 8'sd0, 4'sd0, 4'sd0, 48'd200}, 1'b0, NO_EVENT},
    '{'{3'd0, 8'sd0, 8'sd0, 4'sd0, 4'sd0, 48'd300}, 1'b1,
      '{EV_UP, 48'd300, 3'd0, 2'd0, 25'sd0, 25'sd0, 4'sd0, 4'sd0, 1'b1}},
    // third click, then counter wraps while left goes up
    '{'{3'd3, 8'sd0, 8'sd0, 4'sd0, 4'sd0, 48'd400}, 1'b0, NO_EVENT},
    '{'{3'd2, 8'sd0, 8'sd0, 4'sd0, 4'sd0, 48'd500}, 1'b0, NO_EVENT},
    // far outside the window, then a stamp before the last press
    '{'{3'd7, 8'sd0, 8'sd0, 4'sd0, 4'sd0, 48'd2000000}, 1'b0, NO_EVENT},
    '{'{3'd7, 8'sd0, 8'sd0, 4'sd0, 4'sd0, 48'd100}, 1'b0, NO_EVENT},
    // release with extreme deltas
    '{'{3'd0, 8'sd127, 8'sh80, 4'sd0, 4'sd0, 48'd3000000}, 1'b0, NO_EVENT},
    // tiny deltas get the minimum of one, zero axis stays zero
    '{'{3'd0, 8'sd1, 8'sd0, 4'sd0, 4'sd0, 48'd3000001}, 1'b0, NO_EVENT},
    '{'{3'd0, -8'sd1, 8'sd0, 4'sd7, 4'sh8, 48'd3000002}, 1'b0, NO_EVENT},
    // wheel only
    '{'{3'd0, 8'sd0, 8'sd0, 4'sh8, 4'sd7, 48'd3000010}, 1'b1,
      '{EV_WHEEL, 48'd3000010, 3'd0, 2'd0, 25'sd0, 25'sd0, 4'sh8, 4'sd7, 1'b1}},
    '{'{3'd0, 8'sd0, 8'sd0, 4'sd1, 4'sd0, 48'd3000011}, 1'b1,
      '{EV_WHEEL, 48'd3000011, 3'd0, 2'd0, 25'sd0, 25'sd0, 4'sd1, 4'sd0, 1'b1}},
    // all three events at the top stamp
    '{'{3'd4, 8'sh80, 8'sd127, -4'sd1, -4'sd1, 48'hFFFF_FFFF_FFFF}, 1'b0, NO_EVENT},
    '{'{3'd4, 8'sd0, 8'sd0, 4'sd0, 4'sd0, 48'd0}, 1'b0, NO_EVENT},
    '{'{3'd0, 8'sd0, 8'sd5, 4'sd0, 4'sd0, 48'd0}, 1'b0, NO_EVENT},
    // gap of exactly the window, then two past it
    '{'{3'd1, 8'sd0, 8'sd0, 4'sd0, 4'sd0, 48'd500000}, 1'b0, NO_EVENT},
    '{'{3'd0, 8'sd0, 8'sd0, 4'sd0, 4'sd0, 48'd500001}, 1'b0, NO_EVENT},
    '{'{3'd1, 8'sd0, 8'sd0, 4'sd0, 4'sd0, 48'd1000002}, 1'b0, NO_EVENT},
    '{'{3'd0, 8'sh80, 8'sd0, 4'sd0, 4'sd0, 48'd1000003}, 1'b0, NO_EVENT},
    '{'{3'd0, 8'sd0, 8'sd127, 4'sd0, 4'sd0, 48'd1000004}, 1'b0, NO_EVENT},
    // mixed press and release in one report
    '{'{3'd6, -8'sd1, 8'sd1, 4'sd0, 4'sd0, 48'd1000005}, 1'b0, NO_EVENT},
    '{'{3'd5, 8'sd0, 8'sd0, 4'sd0, 4'sd0, 48'd1000006}, 1'b0, NO_EVENT},
    '{'{3'd0, 8'sd0, 8'sd0, 4'sd0, 4'sd0, 48'd1000007}, 1'b0, NO_EVENT}
  };

  // register settings walked by the random part; one more random setting follows
  localparam int PLAN_N = 6;
  localparam int STEADY_PHASE = 3;
  localparam mouse_setting_t SETTING_PLAN [PLAN_N] = '{
    '{24'd0, 21'd0, 21'd0},
    '{24'hFF_FFFF, 21'h1F_FFFF, 21'd2048},
    '{24'd1000, 21'd32768, 21'h1F_FFFF},
    '{24'd500000, 21'd1048576, 21'd1048576},
    '{24'd50, 21'd32767, 21'd65536},
    '{24'd200000, 21'd65536, 21'd2047}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  cfg_idx_e          cfg_idx;
  logic [CFG_DW-1:0] cfg_data;

  mep_req_if #(.TIME_BITS(TW)) report_ch ();
  mep_evt_if #(.TIME_BITS(TW)) event_ch ();

  mouse_event_processor #(.TIME_BITS(TW)) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (report_ch.sink),
    .evt_o      (event_ch.source)
  );

  // predictor state and its copy of the registers
  logic [BTN_W-1:0] p_held;
  logic [CLK_W-1:0] p_count;
  logic [TW-1:0]    p_last_press;
  logic [CW_W-1:0]  cfg_window;
  logic [SPD_W-1:0] cfg_speed;
  logic [ACC_W-1:0] cfg_accel;

  mouse_event_t  expected_events [$];
  logic [TW-1:0] stamp_now;
  logic          steady;
  int unsigned   failures = 0;
  int unsigned   reports_sent;
  int unsigned   events_checked = 0;
  int unsigned   quiet_cycles = 0;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // accelerated value of one axis, saturated to the pointer range
  function automatic logic signed [XY_W-1:0] scale_axis(input logic signed [DELTA_W-1:0] raw,
                                                        input longint unsigned mul,
                                                        input longint unsigned div);
    longint          sraw;
    longint unsigned mag;
    sraw = raw;
    if (sraw == 0) return '0;
    mag = (sraw < 0) ? -sraw : sraw;
    mag = mag * mul;
    mag = (mag * mag) / div;
    if (mag == 0) mag = 1;
    if (sraw < 0) begin
      if (mag > NEG_LIMIT) mag = NEG_LIMIT;
      return XY_W'(-mag);
    end
    if (mag > POS_LIMIT) mag = POS_LIMIT;
    return XY_W'(mag);
  endfunction

  // events one report causes; queues them and returns how many
  function automatic int predict_events(input mouse_report_t r);
    mouse_event_t    found [$];
    mouse_event_t    ev;
    logic [BTN_W-1:0] changed;
    logic            down;
    longint unsigned mul;
    longint unsigned div;
    changed = p_held ^ r.buttons;

    // multi-click counter on any held button
    if (r.buttons != '0) begin
      if (r.stamp < p_last_press || (r.stamp - p_last_press) <= TW'(cfg_window))
        p_count = (p_count % 2'd3) + 2'd1;
      else
        p_count = 2'd1;
      p_last_press = r.stamp;
    end

    // button down or up
    if (changed != '0) begin
      down = |(changed & r.buttons);
      ev = '0;
      ev.kind = down ? EV_DOWN : EV_UP;
      ev.at = r.stamp;
      ev.buttons = r.buttons;
      ev.clicks = down ? p_count : '0;
      ev.x = r.dx;
      ev.y = r.dy;
      found.push_back(ev);
      p_held = r.buttons;
    end

    // pointer movement
    if (r.dx != 0 || r.dy != 0) begin
      mul = cfg_speed >> MUL_SHIFT;
      div = cfg_accel >> DIV_SHIFT;
      ev = '0;
      ev.kind = EV_MOVED;
      ev.at = r.stamp;
      ev.buttons = r.buttons;
      if (mul != 0 && div != 0) begin
        ev.x = scale_axis(r.dx, mul, div);
        ev.y = scale_axis(r.dy, mul, div);
      end else begin
        ev.x = r.dx;
        ev.y = r.dy;
      end
      found.push_back(ev);
    end

    // wheel
    if (r.wx != 0 || r.wy != 0) begin
      ev = '0;
      ev.kind = EV_WHEEL;
      ev.at = r.stamp;
      ev.wx = r.wx;
      ev.wy = r.wy;
      found.push_back(ev);
    end

    foreach (found[k]) begin
      ev = found[k];
      ev.last = (k == found.size() - 1);
      expected_events.push_back(ev);
    end
    return found.size();
  endfunction

  // report with plausible button sequences and stamps around the click window
  function automatic mouse_report_t random_report();
    mouse_report_t r;
    int unsigned   pick;
    pick = $urandom_range(99);
    if (pick < 40)      r.buttons = p_held;
    else if (pick < 70) r.buttons = '0;
    else                r.buttons = BTN_W'($urandom_range(7));
    r.dx = ($urandom_range(99) < 30) ? '0 : DELTA_W'($urandom);
    r.dy = ($urandom_range(99) < 30) ? '0 : DELTA_W'($urandom);
    r.wx = ($urandom_range(99) < 60) ? '0 : WHEEL_W'($urandom);
    r.wy = ($urandom_range(99) < 60) ? '0 : WHEEL_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 55)
      stamp_now = stamp_now + TW'($urandom_range(0, 32'(cfg_window) * 2 + 2));
    else if (pick < 70)
      stamp_now = p_last_press + TW'(cfg_window) + TW'($urandom_range(1));
    else if (pick < 80)
      stamp_now = stamp_now - TW'($urandom_range(1, 1000));
    else if (pick >= 90)
      stamp_now = TW'({$urandom, $urandom});
    r.stamp = stamp_now;
    return r;
  endfunction

  // one report beat, with an occasional gap before it
  task automatic send_report(input mouse_report_t r);
    if (!steady && $urandom_range(99) < 27) begin
      report_ch.valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 70 : 6)) @(posedge clk);
    end
    report_ch.valid       <= 1'b1;
    report_ch.button_mask <= r.buttons;
    report_ch.dx          <= r.dx;
    report_ch.dy          <= r.dy;
    report_ch.wheel_dx    <= r.wx;
    report_ch.wheel_dy    <= r.wy;
    report_ch.stamp       <= r.stamp;
    do @(posedge clk); while (!report_ch.ready);
    reports_sent++;
  endtask

  // wait for all events, then let the block settle
  task automatic drain_events();
    report_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all three registers on consecutive edges
  task automatic apply_setting(input mouse_setting_t s);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_CLICK_WINDOW;
    cfg_data <= CFG_DW'(s.window);
    @(posedge clk);
    cfg_idx  <= CFG_SPEED;
    cfg_data <= CFG_DW'(s.speed);
    @(posedge clk);
    cfg_idx  <= CFG_ACCEL;
    cfg_data <= CFG_DW'(s.accel);
    @(posedge clk);
    cfg_we     <= 1'b0;
    cfg_window = s.window;
    cfg_speed  = s.speed;
    cfg_accel  = s.accel;
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      failures++;
    end
  endtask

  // event sink readiness, held low during reset
  always @(posedge clk) event_ch.ready <= rst_n && (steady || ($urandom_range(99) >= 27));

  // event checker
  always @(posedge clk) begin
    mouse_event_t ev;
    if (rst_n && event_ch.valid && event_ch.ready) begin
      if (expected_events.size() == 0) begin
        $error("event beat with nothing expected, kind %0d", event_ch.event_kind);
        failures++;
      end else begin
        ev = expected_events.pop_front();
        compare_field("event_kind", ev.kind, event_ch.event_kind);
        compare_field("event_time", ev.at, event_ch.event_time);
        compare_field("event_buttons", ev.buttons, event_ch.event_buttons);
        compare_field("click_number", ev.clicks, event_ch.click_number);
        compare_field("out_x", ev.x, event_ch.out_x);
        compare_field("out_y", ev.y, event_ch.out_y);
        compare_field("out_wheel_x", ev.wx, event_ch.out_wheel_x);
        compare_field("out_wheel_y", ev.wy, event_ch.out_wheel_y);
        compare_field("last", ev.last, event_ch.last);
        events_checked++;
      end
    end
  end

  // watchdog on beats in either direction
  always @(posedge clk) begin
    if ((report_ch.valid && report_ch.ready) || (event_ch.valid && event_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d events outstanding",
               quiet_cycles, expected_events.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    mouse_report_t  rep;
    mouse_setting_t setting;
    int unsigned    done;
    int             produced;

    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = CFG_CLICK_WINDOW;
    cfg_data              = '0;
    report_ch.valid       = 1'b0;
    report_ch.button_mask = '0;
    report_ch.dx          = '0;
    report_ch.dy          = '0;
    report_ch.wheel_dx    = '0;
    report_ch.wheel_dy    = '0;
    report_ch.stamp       = '0;
    steady                = 1'b0;
    reports_sent          = 0;
    p_held                = '0;
    p_count               = '0;
    p_last_press          = '0;
    cfg_window            = CLICK_WINDOW_RST;
    cfg_speed             = SPEED_RST;
    cfg_accel             = ACCEL_RST;
    stamp_now             = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; typed rows replace the predicted event
    foreach (DIRECTED[i]) begin
      send_report(DIRECTED[i].rep);
      produced = predict_events(DIRECTED[i].rep);
      if (DIRECTED[i].typed)
        expected_events[expected_events.size() - 1] = DIRECTED[i].ev;
    end
    stamp_now = DIRECTED[DIR_N-1].rep.stamp;

    // random reports under each register setting
    for (int ph = 0; ph <= PLAN_N; ph++) begin
      drain_events();
      if (ph < PLAN_N) begin
        setting = SETTING_PLAN[ph];
      end else begin
        setting.window = CW_W'($urandom);
        setting.speed  = SPD_W'($urandom_range(0, 1048576));
        setting.accel  = ACC_W'($urandom_range(0, 1048576));
      end
      apply_setting(setting);
      steady = (ph == STEADY_PHASE);
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        rep = random_report();
        send_report(rep);
        produced = predict_events(rep);
        if (produced > 0 || rep.buttons != '0) done++;
      end
    end
    steady = 1'b0;
    drain_events();

    $display("%0d reports over %0d register settings, %0d events checked",
             reports_sent, PLAN_N + 2, events_checked);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", failures);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/mep_pkg.sv
hw/rtl/mep_if.sv
hw/rtl/mep_accel.sv
hw/rtl/mouse_event_processor.sv
sim/mouse_event_processor_test.sv
